// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sb12_pkg.sv
// ----------------------------------------------------------------------------
// sb12_pkg
// Types, constants and helpers of the base-12 ASCII converter.
// ----------------------------------------------------------------------------
package sb12_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX           = 12;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 7;
  localparam int BITS_PER_STEP   = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_B     = 7'd66;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_ELEVEN = 4'd11;

  typedef struct packed {
    logic load;
    logic step;
    logic size;
    logic emit;
  } sb12_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic last_load;
  } sb12_stat_t;

  // number of base-12 digits of the largest magnitude, 2^(w-1)
  function automatic int max_digits(input int w);
    logic [64:0] v;
    int          n;
    int          i;
    v = 65'd1 << (w - 1);
    n = 0;
    for (i = 0; i < 32; i++) begin
      if (v != '0) begin
        v = v / RADIX;
        n = n + 1;
      end
    end
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      DIGIT_TEN:    c = ASCII_A;
      DIGIT_ELEVEN: c = ASCII_B;
      default:      c = ASCII_ZERO + CHAR_W'(d);
    endcase
    return c;
  endfunction

endpackage

// File: src/sb12_in_if.sv
// ----------------------------------------------------------------------------
// sb12_in_if
// Input channel: one signed integer per transaction.
// ----------------------------------------------------------------------------
interface sb12_in_if
  import sb12_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: src/sb12_out_if.sv
// ----------------------------------------------------------------------------
// sb12_out_if
// Result channel: one ASCII character per transaction.
// ----------------------------------------------------------------------------
interface sb12_out_if
  import sb12_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// File: src/sb12_ctrl.sv
// ----------------------------------------------------------------------------
// sb12_ctrl
// Sequencer: accept, convert, size, emit.
// ----------------------------------------------------------------------------
module sb12_ctrl
  import sb12_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sb12_stat_t stat,
  output sb12_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_last) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/sb12_dp.sv
// ----------------------------------------------------------------------------
// sb12_dp
// Datapath: base-12 shift-and-correct digit register and character output.
// ----------------------------------------------------------------------------
module sb12_dp
  import sb12_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int DIGITS      = max_digits(VALUE_WIDTH)
)(
  input  logic                          clk,
  input  logic                          rst_n,
  input  sb12_cmd_t                     cmd,
  output sb12_stat_t                    stat,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [CHAR_W-1:0]             out_character,
  output logic                          out_last
);

  localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PADW   = STEPS * BITS_PER_STEP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [DIGIT_W-1:0] digits_r   [DIGITS];
  logic [DIGIT_W-1:0] digits_nxt [DIGITS];
  logic [PADW-1:0]    mag_r, mag_nxt;
  logic [STEP_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               sign_pend_r, sign_pend_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] raw_u;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   slot_free;
  logic                   emit_fire;
  logic [IDX_W-1:0]       top_idx;

  logic [DIGIT_W-1:0] stage [BITS_PER_STEP+1][DIGITS];
  logic [DIGITS:0]    cy    [BITS_PER_STEP];

  assign raw_u  = in_value;
  assign mag_in = raw_u[VALUE_WIDTH-1] ? (~raw_u + 1'b1) : raw_u;

  // double the base-12 register and add one magnitude bit, four times
  always_comb begin
    logic [DIGIT_W:0] dbl;
    int               b;
    int               i;
    dbl      = '0;
    stage[0] = digits_r;
    for (b = 0; b < BITS_PER_STEP; b++) begin
      cy[b][0] = mag_r[PADW-1-b];
      for (i = 0; i < DIGITS; i++) begin
        cy[b][i+1] = (stage[b][i] >= DIGIT_W'(RADIX / 2));
      end
      for (i = 0; i < DIGITS; i++) begin
        dbl = {stage[b][i], cy[b][i]};
        stage[b+1][i] = cy[b][i+1] ? DIGIT_W'(dbl - (DIGIT_W+1)'(RADIX)) : dbl[DIGIT_W-1:0];
      end
    end
  end

  always_comb begin
    int i;
    top_idx = '0;
    for (i = 0; i < DIGITS; i++) begin
      if (digits_r[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign emit_fire = cmd.emit && slot_free;

  assign stat.conv_last = cmd.step && (step_cnt_r == STEP_W'(STEPS - 1));
  assign stat.last_load = emit_fire && !sign_pend_r && (idx_r == '0);

  always_comb begin
    digits_nxt    = digits_r;
    mag_nxt       = mag_r;
    step_cnt_nxt  = step_cnt_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      for (int i = 0; i < DIGITS; i++) begin
        digits_nxt[i] = '0;
      end
      mag_nxt      = PADW'(mag_in);
      step_cnt_nxt = '0;
      neg_nxt      = raw_u[VALUE_WIDTH-1];
    end

    if (cmd.step) begin
      digits_nxt   = stage[BITS_PER_STEP];
      mag_nxt      = mag_r << BITS_PER_STEP;
      step_cnt_nxt = step_cnt_r + 1'b1;
    end

    if (cmd.size) begin
      idx_nxt       = top_idx;
      sign_pend_nxt = neg_r;
    end

    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      if (sign_pend_r) begin
        out_char_nxt  = ASCII_MINUS;
        out_last_nxt  = 1'b0;
        sign_pend_nxt = 1'b0;
      end else begin
        out_char_nxt = digit_char(digits_r[idx_r]);
        out_last_nxt = (idx_r == '0);
        idx_nxt      = idx_r - 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r  <= '0;
      sign_pend_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      step_cnt_r  <= step_cnt_nxt;
      sign_pend_r <= sign_pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

// File: src/signed_binary_to_base12_ascii.sv
// A value is accepted only while idle and is converted by the four-bit-per-cycle
//   base-12 doubling register; its characters then leave through the single
//   character output register, which holds while it is full and out_ready is low.
//   No new value is taken until the last character of the previous one is loaded.
// Reset: synchronous active low; sequencer idle, output register empty.
// ----------------------------------------------------------------------------
// signed_binary_to_base12_ascii
// Signed integer to base-12 ASCII string, one character per transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_binary_to_base12_ascii
  import sb12_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  sb12_in_if.sink     in_ch,
  sb12_out_if.source  out_ch
);

  localparam int DIGITS = max_digits(VALUE_WIDTH);

  sb12_cmd_t  cmd;
  sb12_stat_t stat;

  sb12_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sb12_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

  `SB_ASSERT_NEXT(a_accept_starts_conv, in_ch.valid && in_ch.ready, cmd.step,
                  "conversion did not start after an input transaction")
  `SB_ASSERT_NEXT(a_last_loaded, stat.last_load, out_ch.valid && out_ch.last,
                  "final character not presented after its load")
  `SB_ASSERT_NOW(a_sign_not_last, out_ch.valid && (out_ch.character == ASCII_MINUS),
                 !out_ch.last, "sign character flagged as last")

endmodule
